// ----- rtl/core/pdf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pdf_pkg;

    localparam int DW          = 32;
    localparam int FRAC        = 16;
    localparam int PROD_W      = 48;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 48;
    localparam int FRONT_DEPTH = 6;
    localparam int TAIL_DEPTH  = 10;
    localparam int PIPE_DEPTH  = FRONT_DEPTH + SQRT_STEPS + DIV_STEPS + TAIL_DEPTH;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int INFL_W      = 49;
    localparam int INFC_W      = 24;
    localparam int NUM_XFORM   = 6;

    typedef logic signed [DW-1:0] q16_t;

    localparam q16_t ONE_Q16  = 32'sh0001_0000;
    localparam q16_t HALF_Q16 = 32'sh0000_8000;
    localparam q16_t Q16_MAX  = 32'sh7FFF_FFFF;
    localparam q16_t Q16_MIN  = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_XF_00_01 = 3'd0,
        REG_XF_02_03 = 3'd1,
        REG_XF_10_11 = 3'd2,
        REG_XF_12_13 = 3'd3,
        REG_XF_20_21 = 3'd4,
        REG_XF_22_23 = 3'd5,
        REG_STRENGTH = 3'd6,
        REG_INFL     = 3'd7
    } cfg_reg_t;

    // Q16.16 product, floored
    function automatic logic signed [PROD_W-1:0] mulq(input q16_t a, input q16_t b);
        logic signed [63:0] prod;
        prod = 64'(a) * 64'(b);
        return prod[63:FRAC];
    endfunction

    function automatic q16_t sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return Q16_MAX;
        else if (x < -64'sd2147483648)
            return Q16_MIN;
        else
            return q16_t'(x);
    endfunction

    function automatic logic [DW-1:0] abs32(input q16_t v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pdf_chan_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pdf_in_if;
    logic         valid;
    logic         ready;
    pdf_pkg::q16_t pos_x;
    pdf_pkg::q16_t pos_y;
    pdf_pkg::q16_t pos_z;
    pdf_pkg::q16_t vel_x;
    pdf_pkg::q16_t vel_y;
    pdf_pkg::q16_t vel_z;
    pdf_pkg::q16_t size_x;
    pdf_pkg::q16_t size_y;
    pdf_pkg::q16_t size_z;
    pdf_pkg::q16_t size_factor;
    pdf_pkg::q16_t weight;
    logic         last_in;

    modport source (
        output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               size_x, size_y, size_z, size_factor, weight, last_in,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               size_x, size_y, size_z, size_factor, weight, last_in,
        output ready
    );
endinterface

interface pdf_out_if;
    logic         valid;
    logic         ready;
    pdf_pkg::q16_t dforce_x;
    pdf_pkg::q16_t dforce_y;
    pdf_pkg::q16_t dforce_z;
    logic         applied;
    logic         last_out;

    modport source (
        output valid, dforce_x, dforce_y, dforce_z, applied, last_out,
        input  ready
    );
    modport sink (
        input  valid, dforce_x, dforce_y, dforce_z, applied, last_out,
        output ready
    );
endinterface

interface pdf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pdf_pkg::CFG_IDX_W-1:0]      index;
    logic [pdf_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pdf_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One root bit per stage, remainder carried along.
module pdf_sqrt (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] radicand,
    output logic [31:0]      root
);

    localparam int N = pdf_pkg::SQRT_STEPS;

    logic [63:0] rad_reg  [N];
    logic [33:0] rem_reg  [N];
    logic [31:0] root_reg [N];
    logic [63:0] rad_next [N];
    logic [33:0] rem_next [N];
    logic [31:0] root_next[N];

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic [63:0] rad_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [35:0] cand;
        logic [35:0] trial;

        if (i == 0)
        begin : g_first
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rad_in  = rad_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
        end

        assign cand  = {rem_in, rad_in[63:62]};
        assign trial = {2'b00, root_in, 2'b01};
        assign rad_next[i]  = {rad_in[61:0], 2'b00};
        assign rem_next[i]  = (cand >= trial) ? 34'(cand - trial) : cand[33:0];
        assign root_next[i] = {root_in[30:0], (cand >= trial)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                rad_reg[i]  <= rad_next[i];
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

`default_nettype wire

// ----- rtl/core/pdf_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divide of (num << 16) by den, one quotient bit per stage.
module pdf_div (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] num,
    input  wire logic [31:0] den,
    output logic [47:0]      quot
);

    localparam int N = pdf_pkg::DIV_STEPS;

    logic [47:0] num_reg  [N];
    logic [31:0] den_reg  [N];
    logic [31:0] rem_reg  [N];
    logic [47:0] quot_reg [N];
    logic [47:0] num_next [N];
    logic [31:0] rem_next [N];
    logic [47:0] quot_next[N];
    logic [31:0] den_next [N];

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic [47:0] num_in;
        logic [31:0] den_in;
        logic [31:0] rem_in;
        logic [47:0] quot_in;
        logic [32:0] cand;
        logic        fits;

        if (i == 0)
        begin : g_first
            assign num_in  = {num, 16'h0000};
            assign den_in  = den;
            assign rem_in  = '0;
            assign quot_in = '0;
        end
        else
        begin : g_rest
            assign num_in  = num_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign quot_in = quot_reg[i-1];
        end

        assign cand = {rem_in, num_in[47]};
        assign fits = (cand >= {1'b0, den_in});
        assign num_next[i]  = {num_in[46:0], 1'b0};
        assign den_next[i]  = den_in;
        assign rem_next[i]  = fits ? 32'(cand - {1'b0, den_in}) : cand[31:0];
        assign quot_next[i] = {quot_in[46:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                num_reg[i]  <= num_next[i];
                den_reg[i]  <= den_next[i];
                rem_reg[i]  <= rem_next[i];
                quot_reg[i] <= quot_next[i];
            end
        end
    end

    assign quot = quot_reg[N-1];

endmodule

`default_nettype wire

// ----- rtl/core/particle_drag_force.sv -----
// A result on drag follows each transaction on particle through 6 front
// stages, 32 square-root stages, 48 divide stages and 10 tail stages.
// Throughput: one particle per cycle; the whole pipe holds only while a
// result waits at the output and drag.ready is low.
// Reset (rst_n low, async): valid bits and all configuration registers clear.
`timescale 1ns / 1ps
`default_nettype none

module particle_drag_force (
    input  wire logic clk,
    input  wire logic rst_n,
    pdf_cfg_if.sink   cfg,
    pdf_in_if.sink    particle,
    pdf_out_if.source drag
);

    localparam int DEPTH = pdf_pkg::PIPE_DEPTH;
    localparam int SN    = pdf_pkg::SQRT_STEPS;
    localparam int DN    = pdf_pkg::DIV_STEPS;

    typedef struct packed {
        pdf_pkg::q16_t h;
        logic [63:0]   sumsq;
        logic [2:0][31:0] mag;
        logic [2:0]    neg;
        logic          ok;
        logic          last;
    } front_t;

    typedef struct packed {
        pdf_pkg::q16_t fs;
        pdf_pkg::q16_t h;
        logic [2:0][31:0] mag;
        logic [2:0]    neg;
        logic          ok;
        logic          last;
    } sq_pl_t;

    typedef struct packed {
        pdf_pkg::q16_t fs;
        pdf_pkg::q16_t h;
        logic [31:0]   speed;
        logic [2:0]    neg;
        logic          ok;
        logic          last;
    } dv_pl_t;

    typedef struct packed {
        logic [2:0][31:0] dir;
        pdf_pkg::q16_t fs;
        pdf_pkg::q16_t h;
        logic          ok;
        logic          last;
    } tail_t;

    // configuration
    logic [63:0]                 xform_reg [pdf_pkg::NUM_XFORM];
    pdf_pkg::q16_t               strength_reg;
    logic [pdf_pkg::INFL_W-1:0]  infl_reg;
    pdf_pkg::q16_t               vinf;
    pdf_pkg::q16_t               sinf;
    pdf_pkg::cfg_reg_t           cfg_sel;

    // pipeline control
    logic [DEPTH-1:0] vld_reg;
    logic             en;

    // stage 1
    pdf_pkg::q16_t p_s1_reg [3];
    pdf_pkg::q16_t v_s1_reg [3];
    pdf_pkg::q16_t sz_s1_reg[3];
    pdf_pkg::q16_t sf_s1_reg;
    pdf_pkg::q16_t wt_s1_reg;
    logic          last_s1_reg;

    // stage 2
    logic signed [47:0] lp_s2_reg [3][3];
    logic signed [47:0] szp_s2_reg[3];
    logic signed [47:0] hp_s2_reg;
    logic [63:0]        sqv_s2_reg[3];
    logic [2:0][31:0]   mag_s2_reg;
    logic [2:0]         neg_s2_reg;
    logic               last_s2_reg;
    pdf_pkg::q16_t      m_el [3][4];

    // stages 3..6
    front_t             fr_s3_reg;
    front_t             fr_s4_reg;
    front_t             fr_s5_reg;
    front_t             fr_s6_reg;
    pdf_pkg::q16_t      area_s3_reg;
    pdf_pkg::q16_t      am1_s4_reg;
    logic signed [47:0] fsp_s5_reg;
    pdf_pkg::q16_t      fs_s6_reg;
    front_t             fr_s3_next;
    pdf_pkg::q16_t      area_s3_next;

    // square root and divide
    sq_pl_t        sq_dl_reg [SN];
    dv_pl_t        dv_dl_reg [DN];
    logic [31:0]   root;
    logic [31:0]   speed;
    logic [47:0]   quot [3];

    // tail
    tail_t              tl_reg [9];
    logic [63:0]        sqp_t1_reg;
    pdf_pkg::q16_t      sqm1_t2_reg;
    logic signed [47:0] pv_t3_reg;
    pdf_pkg::q16_t      fv_t4_reg;
    logic signed [47:0] gp_t5_reg;
    pdf_pkg::q16_t      g_t6_reg;
    logic signed [47:0] mp_t7_reg;
    pdf_pkg::q16_t      m_t8_reg;
    logic signed [47:0] fp_t9_reg [3];
    tail_t              tl_t1_next;
    pdf_pkg::q16_t      sq_t2;

    pdf_pkg::q16_t      dfx_reg;
    pdf_pkg::q16_t      dfy_reg;
    pdf_pkg::q16_t      dfz_reg;
    logic               applied_reg;
    logic               last_out_reg;

    assign en             = !vld_reg[DEPTH-1] || drag.ready;
    assign particle.ready = en;
    assign cfg.ready      = 1'b1;
    assign cfg_sel        = pdf_pkg::cfg_reg_t'(cfg.index);
    assign vinf = pdf_pkg::q16_t'($signed(infl_reg[pdf_pkg::INFC_W-1:0]));
    assign sinf = pdf_pkg::q16_t'($signed(infl_reg[2*pdf_pkg::INFC_W-1:pdf_pkg::INFC_W]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pdf_pkg::NUM_XFORM; i++)
                xform_reg[i] <= '0;
            strength_reg <= '0;
            infl_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_sel) inside
                pdf_pkg::REG_XF_00_01, pdf_pkg::REG_XF_02_03,
                pdf_pkg::REG_XF_10_11, pdf_pkg::REG_XF_12_13,
                pdf_pkg::REG_XF_20_21, pdf_pkg::REG_XF_22_23:
                    xform_reg[cfg.index] <= cfg.data;
                pdf_pkg::REG_STRENGTH:
                    strength_reg <= pdf_pkg::q16_t'(cfg.data[31:0]);
                pdf_pkg::REG_INFL:
                    infl_reg <= cfg.data[pdf_pkg::INFL_W-1:0];
                default:
                    infl_reg <= infl_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], particle.valid};
    end

    // matrix elements: row r, col 0..2, translation in col 3
    always_comb
    begin
        m_el[0][0] = xform_reg[0][31:0];  m_el[0][1] = xform_reg[0][63:32];
        m_el[0][2] = xform_reg[1][31:0];  m_el[0][3] = xform_reg[1][63:32];
        m_el[1][0] = xform_reg[2][31:0];  m_el[1][1] = xform_reg[2][63:32];
        m_el[1][2] = xform_reg[3][31:0];  m_el[1][3] = xform_reg[3][63:32];
        m_el[2][0] = xform_reg[4][31:0];  m_el[2][1] = xform_reg[4][63:32];
        m_el[2][2] = xform_reg[5][31:0];  m_el[2][3] = xform_reg[5][63:32];
    end

    // stage 3 combinational: box test, area, sum of squares
    always_comb
    begin
        logic signed [63:0] loc;
        logic               in_box;
        pdf_pkg::q16_t      s;
        in_box       = 1'b1;
        area_s3_next = pdf_pkg::sat32(64'(szp_s2_reg[0]));
        for (int r = 0; r < 3; r++)
        begin
            loc = 64'(lp_s2_reg[r][0]) + 64'(lp_s2_reg[r][1])
                + 64'(lp_s2_reg[r][2]) + 64'(m_el[r][3]);
            if (loc < -64'(pdf_pkg::HALF_Q16) || loc > 64'(pdf_pkg::HALF_Q16))
                in_box = 1'b0;
        end
        for (int i = 1; i < 3; i++)
        begin
            s = pdf_pkg::sat32(64'(szp_s2_reg[i]));
            if (s > area_s3_next)
                area_s3_next = s;
        end
        fr_s3_next.h     = pdf_pkg::sat32(64'(hp_s2_reg));
        fr_s3_next.sumsq = sqv_s2_reg[0] + sqv_s2_reg[1] + sqv_s2_reg[2];
        fr_s3_next.mag   = mag_s2_reg;
        fr_s3_next.neg   = neg_s2_reg;
        fr_s3_next.ok    = in_box || infl_reg[pdf_pkg::INFL_W-1];
        fr_s3_next.last  = last_s2_reg;
    end

    // front stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_s1_reg[0]  <= particle.pos_x;
            p_s1_reg[1]  <= particle.pos_y;
            p_s1_reg[2]  <= particle.pos_z;
            v_s1_reg[0]  <= particle.vel_x;
            v_s1_reg[1]  <= particle.vel_y;
            v_s1_reg[2]  <= particle.vel_z;
            sz_s1_reg[0] <= particle.size_x;
            sz_s1_reg[1] <= particle.size_y;
            sz_s1_reg[2] <= particle.size_z;
            sf_s1_reg    <= particle.size_factor;
            wt_s1_reg    <= particle.weight;
            last_s1_reg  <= particle.last_in;

            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    lp_s2_reg[r][c] <= pdf_pkg::mulq(m_el[r][c], p_s1_reg[c]);
            for (int i = 0; i < 3; i++)
            begin
                szp_s2_reg[i] <= pdf_pkg::mulq(sz_s1_reg[i], sf_s1_reg);
                sqv_s2_reg[i] <= 64'(pdf_pkg::abs32(v_s1_reg[i]))
                               * 64'(pdf_pkg::abs32(v_s1_reg[i]));
                mag_s2_reg[i] <= pdf_pkg::abs32(v_s1_reg[i]);
                neg_s2_reg[i] <= v_s1_reg[i][31];
            end
            hp_s2_reg   <= pdf_pkg::mulq(strength_reg, wt_s1_reg);
            last_s2_reg <= last_s1_reg;

            fr_s3_reg   <= fr_s3_next;
            area_s3_reg <= area_s3_next;

            fr_s4_reg  <= fr_s3_reg;
            am1_s4_reg <= pdf_pkg::sat32(64'(area_s3_reg) - 64'(pdf_pkg::ONE_Q16));

            fr_s5_reg  <= fr_s4_reg;
            fsp_s5_reg <= pdf_pkg::mulq(am1_s4_reg, sinf);

            fr_s6_reg <= fr_s5_reg;
            fs_s6_reg <= pdf_pkg::sat32(64'(pdf_pkg::ONE_Q16) + 64'(fsp_s5_reg));
        end
    end

    pdf_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (fr_s6_reg.sumsq),
        .root     (root)
    );

    assign speed = (root == '0) ? 32'd1 : root;

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        pdf_div u_div (
            .clk  (clk),
            .en   (en),
            .num  (sq_dl_reg[SN-1].mag[i]),
            .den  (speed),
            .quot (quot[i])
        );
    end

    // payload alongside the root and divide stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_dl_reg[0].fs   <= fs_s6_reg;
            sq_dl_reg[0].h    <= fr_s6_reg.h;
            sq_dl_reg[0].mag  <= fr_s6_reg.mag;
            sq_dl_reg[0].neg  <= fr_s6_reg.neg;
            sq_dl_reg[0].ok   <= fr_s6_reg.ok;
            sq_dl_reg[0].last <= fr_s6_reg.last;
            for (int i = 1; i < SN; i++)
                sq_dl_reg[i] <= sq_dl_reg[i-1];

            dv_dl_reg[0].fs    <= sq_dl_reg[SN-1].fs;
            dv_dl_reg[0].h     <= sq_dl_reg[SN-1].h;
            dv_dl_reg[0].speed <= speed;
            dv_dl_reg[0].neg   <= sq_dl_reg[SN-1].neg;
            dv_dl_reg[0].ok    <= sq_dl_reg[SN-1].ok;
            dv_dl_reg[0].last  <= sq_dl_reg[SN-1].last;
            for (int i = 1; i < DN; i++)
                dv_dl_reg[i] <= dv_dl_reg[i-1];
        end
    end

    always_comb
    begin
        logic signed [63:0] qs;
        for (int i = 0; i < 3; i++)
        begin
            qs = $signed(64'(quot[i]));
            tl_t1_next.dir[i] = pdf_pkg::sat32(dv_dl_reg[DN-1].neg[i] ? -qs : qs);
        end
        tl_t1_next.fs   = dv_dl_reg[DN-1].fs;
        tl_t1_next.h    = dv_dl_reg[DN-1].h;
        tl_t1_next.ok   = dv_dl_reg[DN-1].ok;
        tl_t1_next.last = dv_dl_reg[DN-1].last;
    end

    assign sq_t2 = (sqp_t1_reg[63:47] != '0) ? pdf_pkg::Q16_MAX
                                              : pdf_pkg::q16_t'({1'b0, sqp_t1_reg[46:16]});

    // tail: speed squared, gain chain, final product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tl_reg[0]  <= tl_t1_next;
            sqp_t1_reg <= 64'(dv_dl_reg[DN-1].speed) * 64'(dv_dl_reg[DN-1].speed);
            for (int i = 1; i < 9; i++)
                tl_reg[i] <= tl_reg[i-1];

            sqm1_t2_reg <= sq_t2 - pdf_pkg::ONE_Q16;
            pv_t3_reg   <= pdf_pkg::mulq(sqm1_t2_reg, vinf);
            fv_t4_reg   <= pdf_pkg::sat32(64'(pdf_pkg::ONE_Q16) + 64'(pv_t3_reg));
            gp_t5_reg   <= pdf_pkg::mulq(fv_t4_reg, tl_reg[3].fs);
            g_t6_reg    <= pdf_pkg::sat32(64'(gp_t5_reg));
            mp_t7_reg   <= pdf_pkg::mulq(g_t6_reg, tl_reg[5].h);
            m_t8_reg    <= pdf_pkg::sat32(64'(mp_t7_reg));
            for (int i = 0; i < 3; i++)
                fp_t9_reg[i] <= pdf_pkg::mulq(pdf_pkg::q16_t'(tl_reg[7].dir[i]), m_t8_reg);

            if (tl_reg[8].ok)
            begin
                dfx_reg <= pdf_pkg::sat32(-64'(fp_t9_reg[0]));
                dfy_reg <= pdf_pkg::sat32(-64'(fp_t9_reg[1]));
                dfz_reg <= pdf_pkg::sat32(-64'(fp_t9_reg[2]));
            end
            else
            begin
                dfx_reg <= '0;
                dfy_reg <= '0;
                dfz_reg <= '0;
            end
            applied_reg  <= tl_reg[8].ok;
            last_out_reg <= tl_reg[8].last;
        end
    end

    assign drag.valid    = vld_reg[DEPTH-1];
    assign drag.dforce_x = dfx_reg;
    assign drag.dforce_y = dfy_reg;
    assign drag.dforce_z = dfz_reg;
    assign drag.applied  = applied_reg;
    assign drag.last_out = last_out_reg;

    a_zero_when_not_applied: assert property (@(posedge clk) disable iff (!rst_n)
        drag.valid && !drag.applied |->
            drag.dforce_x == '0 && drag.dforce_y == '0 && drag.dforce_z == '0)
        else $error("force nonzero on particle outside field");

    a_pipe_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");

    a_out_valid_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[DEPTH-2] |=> drag.valid)
        else $error("transaction lost at output stage");

endmodule

`default_nettype wire
